@@ sv/tbd_pkg.sv @@
// Shared types and constants for the two-button debounce machine.
`default_nettype none

package tbd_pkg;

  // Widths of the item fields and of the configuration port
  localparam int unsigned TimeW  = 32;
  localparam int unsigned SpanW  = 16;
  localparam int unsigned RepW   = 2;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned DataW  = 32;

  // Reset value of every settle and poll interval
  localparam logic [SpanW-1:0] SpanReset = SpanW'(20);

  // Command codes
  localparam logic CmdPress = 1'b0;
  localparam logic CmdTick  = 1'b1;

  // Register indexes (word address)
  localparam logic [1:0] RegPressSettle   = 2'd0;
  localparam logic [1:0] RegReleaseSettle = 2'd1;
  localparam logic [1:0] RegReleasePoll   = 2'd2;

  // Phases of the debounce machine
  typedef enum logic [2:0] {
    PH_IDLE         = 3'd0,
    PH_WAIT_PRESS   = 3'd1,
    PH_REPORT       = 3'd2,
    PH_WAIT_RELEASE = 3'd3,
    PH_WAIT_SETTLE  = 3'd4
  } phase_t;

  // Report codes
  typedef enum logic [RepW-1:0] {
    REP_NONE  = 2'd0,
    REP_LEFT  = 2'd1,
    REP_RIGHT = 2'd2
  } report_t;

  // One input item as held in the input register
  typedef struct packed {
    logic             command;
    logic             button_right;
    logic [TimeW-1:0] now;
    logic             all_released;
  } item_t;

  // Interval settings handed to the machine
  typedef struct packed {
    logic [SpanW-1:0] press_settle;
    logic [SpanW-1:0] release_settle;
    logic [SpanW-1:0] release_poll;
  } spans_t;

endpackage

`default_nettype wire

@@ sv/tbd_if.sv @@
// Valid/ready channel interfaces for input items and press reports.
`default_nettype none

interface tbd_in_if;
  logic                     valid;
  logic                     ready;
  logic                     command;
  logic                     button_right;
  logic [tbd_pkg::TimeW-1:0] now;
  logic                     all_released;

  modport source (output valid, command, button_right, now, all_released, input ready);
  modport sink   (input valid, command, button_right, now, all_released, output ready);
endinterface

interface tbd_out_if;
  logic                     valid;
  logic                     ready;
  logic [tbd_pkg::RepW-1:0] press_report;

  modport source (output valid, press_report, input ready);
  modport sink   (input valid, press_report, output ready);
endinterface

`default_nettype wire

@@ sv/tbd_fsm.sv @@
// Debounce state machine: phase, press time mark and latched button.
`default_nettype none

module tbd_fsm (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step,
  input  tbd_pkg::item_t       item,
  input  tbd_pkg::spans_t      spans,
  output tbd_pkg::report_t     report
);
  import tbd_pkg::*;

  phase_t           phase_r, phase_nxt;
  logic [TimeW-1:0] mark_r, mark_nxt;
  logic             latched_r, latched_nxt;

  logic [TimeW-1:0] delta;
  logic             press_done, poll_due, settle_done;

  // Time since the last mark, modulo 2^32
  assign delta       = item.now - mark_r;
  assign press_done  = delta >= {{(TimeW-SpanW){1'b0}}, spans.press_settle};
  assign poll_due    = delta >= {{(TimeW-SpanW){1'b0}}, spans.release_poll};
  assign settle_done = delta >= {{(TimeW-SpanW){1'b0}}, spans.release_settle};

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (item.command == CmdPress) begin
      if (phase_r == PH_IDLE) phase_nxt = PH_WAIT_PRESS;
    end else begin
      unique case (phase_r)
        PH_WAIT_PRESS:   if (press_done) phase_nxt = PH_REPORT;
        PH_REPORT:       phase_nxt = PH_WAIT_RELEASE;
        PH_WAIT_RELEASE: if (poll_due && item.all_released) phase_nxt = PH_WAIT_SETTLE;
        PH_WAIT_SETTLE:  if (settle_done) phase_nxt = PH_IDLE;
        default:         phase_nxt = phase_r;
      endcase
    end
  end

  // Mark, latch and report
  always_comb begin
    mark_nxt    = mark_r;
    latched_nxt = latched_r;
    report      = REP_NONE;
    if (item.command == CmdPress) begin
      if (phase_r == PH_IDLE) begin
        mark_nxt    = item.now;
        latched_nxt = item.button_right;
      end
    end else begin
      unique case (phase_r)
        PH_WAIT_PRESS:   if (press_done) mark_nxt = item.now;
        PH_REPORT:       report = latched_r ? REP_RIGHT : REP_LEFT;
        PH_WAIT_RELEASE: if (poll_due) mark_nxt = item.now;
        default:         report = REP_NONE;
      endcase
    end
  end

  // Advance on each item leaving the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      mark_r    <= '0;
      latched_r <= 1'b0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      mark_r    <= mark_nxt;
      latched_r <= latched_nxt;
    end
  end

endmodule

`default_nettype wire

@@ sv/two_button_debounce_fsm.sv @@
// Top level: input register, debounce machine, result register and APB registers.
//
//   channel   direction  handshake        payload
//   in_chan   in         valid/ready      command, button_right, now, all_released
//   out_chan  out        valid/ready      press_report
//   apb       in         psel/penable     press/release settle, release poll (16 bit each)
//
// Every beat yields exactly one result beat via the input and result registers.
// One beat is accepted per cycle while in_chan.ready is high; the machine steps
// once per item in the cycle it leaves the input register for the result register.
// A stalled result holds the result register; the input register then holds
// one further item, and in_chan.ready drops only when both are full.
// Synchronous active-low reset empties both registers, idles the machine and
// sets every interval to 20 ticks.
`default_nettype none

module two_button_debounce_fsm (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  tbd_in_if.sink                        in_chan,
  tbd_out_if.source                     out_chan,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [tbd_pkg::AddrW-1:0] paddr,
  input  wire logic [tbd_pkg::DataW-1:0] pwdata,
  output      logic [tbd_pkg::DataW-1:0] prdata,
  output      logic                     pready
);
  import tbd_pkg::*;

  spans_t           spans_r;
  item_t            item_r;
  logic             item_vld_r;
  logic [RepW-1:0]  rep_r;
  logic             rep_vld_r;
  report_t          report;
  logic             rep_free, step, cfg_wr;
  logic [1:0]       reg_idx;

  // Register file
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[AddrW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spans_r.press_settle   <= SpanReset;
      spans_r.release_settle <= SpanReset;
      spans_r.release_poll   <= SpanReset;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        RegPressSettle:   spans_r.press_settle   <= pwdata[SpanW-1:0];
        RegReleaseSettle: spans_r.release_settle <= pwdata[SpanW-1:0];
        RegReleasePoll:   spans_r.release_poll   <= pwdata[SpanW-1:0];
        default:          spans_r <= spans_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegPressSettle:   prdata = {{(DataW-SpanW){1'b0}}, spans_r.press_settle};
      RegReleaseSettle: prdata = {{(DataW-SpanW){1'b0}}, spans_r.release_settle};
      RegReleasePoll:   prdata = {{(DataW-SpanW){1'b0}}, spans_r.release_poll};
      default:          prdata = '0;
    endcase
  end

  // Pipeline flow
  assign rep_free      = !rep_vld_r || out_chan.ready;
  assign step          = item_vld_r && rep_free;
  assign in_chan.ready = !item_vld_r || rep_free;

  // Input register: take a beat whenever the stage drains
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_chan.ready) begin
      item_vld_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      item_r.command      <= in_chan.command;
      item_r.button_right <= in_chan.button_right;
      item_r.now          <= in_chan.now;
      item_r.all_released <= in_chan.all_released;
    end
  end

  tbd_fsm u_fsm (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (item_r),
    .spans  (spans_r),
    .report (report)
  );

  // Result register: hold until the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rep_vld_r <= 1'b0;
    end else if (rep_free) begin
      rep_vld_r <= item_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) rep_r <= report;
  end

  assign out_chan.valid        = rep_vld_r;
  assign out_chan.press_report = rep_r;

endmodule

`default_nettype wire
